### src/slice_accessor_token_parser_top_assert.svh
// Assertion macros for the accessor-chain token parser.
// Used by the parser core; needs a clk and rst_n in scope.
`ifndef SLICE_ACCESSOR_TOKEN_PARSER_TOP_ASSERT_SVH
`define SLICE_ACCESSOR_TOKEN_PARSER_TOP_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define SAT_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset.
`define SAT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/sat_pkg.sv
// Shared types and codes for the accessor-chain token parser.
// No dependencies.
`default_nettype none

package sat_pkg;

  localparam logic [2:0] TK_DOT    = 3'd0;
  localparam logic [2:0] TK_IDENT  = 3'd1;
  localparam logic [2:0] TK_LBRACK = 3'd2;
  localparam logic [2:0] TK_RBRACK = 3'd3;
  localparam logic [2:0] TK_COLON  = 3'd4;
  localparam logic [2:0] TK_INT    = 3'd5;
  localparam logic [2:0] TK_OTHER  = 3'd6;
  localparam logic [2:0] TK_END    = 3'd7;

  localparam logic [1:0] NODE_TAKE   = 2'd0;
  localparam logic [1:0] NODE_SELECT = 2'd1;
  localparam logic [1:0] NODE_RANGE  = 2'd2;
  localparam logic [1:0] NODE_ERROR  = 2'd3;

  localparam logic [1:0] ERR_NONE     = 2'd0;
  localparam logic [1:0] ERR_IDENT    = 2'd1;
  localparam logic [1:0] ERR_COLON_BR = 2'd2;
  localparam logic [1:0] ERR_CLOSE_BR = 2'd3;

  typedef enum logic [3:0] {
    PH_WAIT_OP    = 4'd0,
    PH_WANT_IDENT = 4'd1,
    PH_OPEN       = 4'd2,
    PH_HAVE_START = 4'd3,
    PH_COLON1     = 4'd4,
    PH_HAVE_STOP  = 4'd5,
    PH_COLON2     = 4'd6,
    PH_HAVE_STEP  = 4'd7,
    PH_SKIP       = 4'd8
  } phase_t;

  typedef struct packed {
    logic [2:0]  token_kind;
    logic [63:0] token_value;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  node_kind;
    logic [63:0] key_handle;
    logic [63:0] range_start;
    logic [63:0] range_stop;
    logic [63:0] range_step;
    logic [1:0]  error_code;
    logic        last_of_chain;
  } out_item_t;

  typedef struct packed {
    logic      produce;
    out_item_t item;
  } result_t;

endpackage

`default_nettype wire

### src/sat_in_stage.sv
// Input register stage: holds one token request until the parser takes it.
// Depends on sat_pkg.
`default_nettype none

module sat_in_stage
  import sat_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire in_item_t in_data,
  input  wire logic     advance,
  output logic          tok_valid,
  output in_item_t      tok_data
);

  logic     valid_r, valid_nxt;
  in_item_t data_r;
  logic     take;

  assign in_stall  = valid_r && !advance;
  assign take      = in_valid && !in_stall;
  assign tok_valid = valid_r;
  assign tok_data  = data_r;

  always_comb begin
    valid_nxt = valid_r;
    if (take) begin
      valid_nxt = 1'b1;
    end else if (advance) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      data_r <= in_data;
    end
  end

endmodule

`default_nettype wire

### src/sat_parser.sv
// Parser core: phase state machine, pending range registers and result build.
// Depends on sat_pkg and slice_accessor_token_parser_top_assert.svh.
`default_nettype none

module sat_parser
  import sat_pkg::*;
#(
  parameter int INDEX_BITS = 64
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     fire,
  input  wire in_item_t tok,
  output result_t       res
);

  localparam logic [63:0] IDX_MASK = {64{1'b1}} >> (64 - INDEX_BITS);
  localparam logic [INDEX_BITS-1:0] ONES = {INDEX_BITS{1'b1}};
  localparam logic [INDEX_BITS-1:0] ONE  = {{(INDEX_BITS-1){1'b0}}, 1'b1};

  phase_t                phase_r, phase_nxt;
  logic [INDEX_BITS-1:0] start_r, start_nxt;
  logic [INDEX_BITS-1:0] stop_r, stop_nxt;
  logic [INDEX_BITS-1:0] step_r, step_nxt;
  logic [INDEX_BITS-1:0] num;
  logic [INDEX_BITS-1:0] start_inc;
  logic                  is_end;
  logic [2:0]            kind;
  phase_t                err_phase;

  assign kind      = tok.token_kind;
  assign num       = tok.token_value[INDEX_BITS-1:0];
  assign start_inc = start_r + ONE;
  assign is_end    = (kind == TK_END);
  assign err_phase = is_end ? PH_WAIT_OP : PH_SKIP;

  always_comb begin
    phase_nxt = phase_r;
    start_nxt = start_r;
    stop_nxt  = stop_r;
    step_nxt  = step_r;
    if (fire) begin
      unique case (phase_r)
        PH_WAIT_OP: begin
          if (kind == TK_DOT) begin
            phase_nxt = PH_WANT_IDENT;
          end else if (kind == TK_LBRACK) begin
            start_nxt = ONES;
            stop_nxt  = ONES;
            step_nxt  = ONES;
            phase_nxt = PH_OPEN;
          end else begin
            phase_nxt = err_phase;
          end
        end
        PH_WANT_IDENT: begin
          phase_nxt = (kind == TK_IDENT) ? PH_WAIT_OP : err_phase;
        end
        PH_OPEN: begin
          if (kind == TK_RBRACK) begin
            phase_nxt = PH_WAIT_OP;
          end else if (kind == TK_INT) begin
            start_nxt = num;
            phase_nxt = PH_HAVE_START;
          end else if (kind == TK_COLON) begin
            phase_nxt = PH_COLON1;
          end else begin
            phase_nxt = err_phase;
          end
        end
        PH_HAVE_START: begin
          if (kind == TK_RBRACK) begin
            stop_nxt  = start_inc;
            step_nxt  = ONE;
            phase_nxt = PH_WAIT_OP;
          end else if (kind == TK_COLON) begin
            phase_nxt = PH_COLON1;
          end else begin
            phase_nxt = err_phase;
          end
        end
        PH_COLON1: begin
          if (kind == TK_INT) begin
            stop_nxt  = num;
            phase_nxt = PH_HAVE_STOP;
          end else if (kind == TK_COLON) begin
            phase_nxt = PH_COLON2;
          end else if (kind == TK_RBRACK) begin
            phase_nxt = PH_WAIT_OP;
          end else begin
            phase_nxt = err_phase;
          end
        end
        PH_HAVE_STOP: begin
          if (kind == TK_COLON) begin
            phase_nxt = PH_COLON2;
          end else if (kind == TK_RBRACK) begin
            phase_nxt = PH_WAIT_OP;
          end else begin
            phase_nxt = err_phase;
          end
        end
        PH_COLON2: begin
          if (kind == TK_INT) begin
            step_nxt  = num;
            phase_nxt = PH_HAVE_STEP;
          end else if (kind == TK_RBRACK) begin
            phase_nxt = PH_WAIT_OP;
          end else begin
            phase_nxt = err_phase;
          end
        end
        PH_HAVE_STEP: begin
          phase_nxt = (kind == TK_RBRACK) ? PH_WAIT_OP : err_phase;
        end
        default: begin
          phase_nxt = is_end ? PH_WAIT_OP : PH_SKIP;
        end
      endcase
    end
  end

  always_comb begin
    res                    = '0;
    res.item.node_kind     = NODE_TAKE;
    res.item.key_handle    = 64'd0;
    res.item.range_start   = IDX_MASK;
    res.item.range_stop    = IDX_MASK;
    res.item.range_step    = IDX_MASK;
    res.item.error_code    = ERR_NONE;
    res.item.last_of_chain = 1'b0;
    if (fire) begin
      unique case (phase_r)
        PH_WAIT_OP: begin
          if (kind != TK_DOT && kind != TK_LBRACK) begin
            res.produce            = 1'b1;
            res.item.last_of_chain = 1'b1;
          end
        end
        PH_WANT_IDENT: begin
          res.produce = 1'b1;
          if (kind == TK_IDENT) begin
            res.item.node_kind  = NODE_SELECT;
            res.item.key_handle = tok.token_value;
          end else begin
            res.item.node_kind     = NODE_ERROR;
            res.item.error_code    = ERR_IDENT;
            res.item.last_of_chain = 1'b1;
          end
        end
        PH_OPEN, PH_HAVE_START: begin
          if (kind == TK_RBRACK) begin
            res.produce          = 1'b1;
            res.item.node_kind   = NODE_RANGE;
            res.item.range_start = 64'(start_r);
            res.item.range_stop  = (phase_r == PH_HAVE_START) ? 64'(start_inc)
                                                              : 64'(stop_r);
            res.item.range_step  = (phase_r == PH_HAVE_START) ? 64'(ONE)
                                                              : 64'(step_r);
          end else if (!(kind == TK_COLON ||
                         (kind == TK_INT && phase_r == PH_OPEN))) begin
            res.produce            = 1'b1;
            res.item.node_kind     = NODE_ERROR;
            res.item.error_code    = ERR_COLON_BR;
            res.item.last_of_chain = 1'b1;
          end
        end
        PH_COLON1, PH_HAVE_STOP, PH_COLON2, PH_HAVE_STEP: begin
          if (kind == TK_RBRACK) begin
            res.produce          = 1'b1;
            res.item.node_kind   = NODE_RANGE;
            res.item.range_start = 64'(start_r);
            res.item.range_stop  = 64'(stop_r);
            res.item.range_step  = 64'(step_r);
          end else if (!((kind == TK_INT &&
                          (phase_r == PH_COLON1 || phase_r == PH_COLON2)) ||
                         (kind == TK_COLON &&
                          (phase_r == PH_COLON1 || phase_r == PH_HAVE_STOP)))) begin
            res.produce            = 1'b1;
            res.item.node_kind     = NODE_ERROR;
            res.item.error_code    = ERR_CLOSE_BR;
            res.item.last_of_chain = 1'b1;
          end
        end
        default: begin
          res.produce = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_WAIT_OP;
      start_r <= ONES;
      stop_r  <= ONES;
      step_r  <= ONES;
    end else begin
      phase_r <= phase_nxt;
      start_r <= start_nxt;
      stop_r  <= stop_nxt;
      step_r  <= step_nxt;
    end
  end

`include "slice_accessor_token_parser_top_assert.svh"

  `SAT_ASSERT_IMPL(a_skip_silent, fire && phase_r == PH_SKIP, !res.produce, "result while skipping")
  `SAT_ASSERT_IMPL(a_last_iff_end, res.produce, res.item.last_of_chain == (res.item.node_kind == NODE_TAKE || res.item.node_kind == NODE_ERROR), "last flag mismatch")
  `SAT_ASSERT_IMPL(a_key_only_select, res.produce && res.item.node_kind != NODE_SELECT, res.item.key_handle == 64'd0, "key on non-select")
  `SAT_ASSERT_NEXT(a_end_restarts, fire && is_end && phase_r != PH_OPEN && phase_r != PH_COLON1, phase_r == PH_WAIT_OP, "end item did not restart")

endmodule

`default_nettype wire

### src/sat_out_stage.sv
// Output register stage: holds one result request until the sink takes it.
// Depends on sat_pkg.
`default_nettype none

module sat_out_stage
  import sat_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    advance,
  input  wire result_t res,
  output logic         out_free,
  output logic         out_valid,
  input  wire logic    out_stall,
  output out_item_t    out_data
);

  logic      valid_r, valid_nxt;
  out_item_t data_r;
  logic      load;

  assign out_free  = !valid_r || !out_stall;
  assign load      = advance && res.produce;
  assign out_valid = valid_r;
  assign out_data  = data_r;

  always_comb begin
    valid_nxt = valid_r;
    if (out_free) begin
      valid_nxt = load;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= res.item;
    end
  end

endmodule

`default_nettype wire

### src/slice_accessor_token_parser_top.sv
// Accessor-chain token parser: one token request in, at most one result out.
// Each accepted token waits in the input register; its result goes to the output register.
// Throughput: one token per cycle while out_free, one state update per token.
// A stalled output holds the parser; the input register then stalls in_valid.
// Reset (rst_n low, synchronous): phase to waiting for an operation, pending
// range values to all ones, both pipeline registers emptied.
`default_nettype none

module slice_accessor_token_parser_top
  import sat_pkg::*;
#(
  parameter int INDEX_BITS = 64
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire in_item_t in_data,
  output logic          out_valid,
  input  wire logic     out_stall,
  output out_item_t     out_data
);

  logic     tok_valid;
  in_item_t tok_data;
  logic     out_free;
  logic     advance;
  result_t  res;

  assign advance = tok_valid && out_free;

  sat_in_stage u_in (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .advance   (advance),
    .tok_valid (tok_valid),
    .tok_data  (tok_data)
  );

  sat_parser #(
    .INDEX_BITS (INDEX_BITS)
  ) u_parser (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (advance),
    .tok   (tok_data),
    .res   (res)
  );

  sat_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .advance   (advance),
    .res       (res),
    .out_free  (out_free),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire
